[rtl/core/weighted_mean_accumulator_core_defines.svh]
// ----------------------------------------------------------------------------
// Weighted mean accumulator assertion macros
// Shared concurrent assertion wrappers for the accumulator core modules.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MEAN_ACCUMULATOR_CORE_DEFINES_SVH
`define WEIGHTED_MEAN_ACCUMULATOR_CORE_DEFINES_SVH

// Assertion on a named clock, disabled while the active-low reset is asserted.
`define WMA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the standard clk_i / rst_ni pair of the core.
`define WMA_ASSERT(lbl, prop, msg) `WMA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/wma_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted mean accumulator package
// Constants, codes and shared types of the weighted mean accumulator core.
// ----------------------------------------------------------------------------
package wma_pkg;

  // Number of element sums kept in the store.
  localparam int VECTOR_LEN = 64;
  localparam int ADDR_W     = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

  // Datapath widths.
  localparam int SUM_W      = 64;
  localparam int TOT_W      = 32;
  localparam int MEAN_W     = 32;

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Item function codes (code three is unused and completes with no effect).
  typedef enum logic [1:0] {
    FUNC_ACC   = 2'd0,
    FUNC_MERGE = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WEIGHT   = 2'd1,
    ST_CONSUMED = 2'd2,
    ST_ZERODIV  = 2'd3
  } status_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RMW  = 2'd1,
    S_DIV  = 2'd2
  } state_e;

  // Request to the single-port sum store.
  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  wdata;
  } ram_req_t;

endpackage

[rtl/core/wma_sum_ram.sv]
// ----------------------------------------------------------------------------
// Weighted mean accumulator sum store
// Single-port synchronous memory of element sums with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module wma_sum_ram (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wma_pkg::ram_req_t        req_i,
  output logic [wma_pkg::SUM_W-1:0] rdata_o
);

  logic [wma_pkg::SUM_W-1:0]      mem [wma_pkg::VECTOR_LEN];
  logic [wma_pkg::VECTOR_LEN-1:0] valid_q;
  logic [wma_pkg::SUM_W-1:0]      rdata_q;
  logic                           rvalid_q;

  // Storage array and registered read data.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // Valid bits are cleared by reset and set on the first write of an entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.addr];
      end
    end
  end

  // An entry that was never written reads as its reset value of zero.
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[rtl/core/wma_divider.sv]
// ----------------------------------------------------------------------------
// Weighted mean accumulator divider
// Unsigned restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. The quotient holds after completion.
// ----------------------------------------------------------------------------
module wma_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wma_pkg::SUM_W-1:0] dividend_i,
  input  logic [wma_pkg::TOT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [wma_pkg::SUM_W-1:0] quotient_o
);

  logic                          busy_q;
  logic [wma_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [wma_pkg::SUM_W-1:0]     quo_q;
  logic [wma_pkg::TOT_W-1:0]     rem_q;
  logic [wma_pkg::TOT_W-1:0]     dsr_q;
  logic [wma_pkg::TOT_W:0]       trial;
  logic [wma_pkg::TOT_W:0]       diff;
  logic                          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[wma_pkg::SUM_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= wma_pkg::DIV_CNT_W'(wma_pkg::DIV_STEPS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[wma_pkg::SUM_W-2:0], fits};
      rem_q <= fits ? diff[wma_pkg::TOT_W-1:0] : trial[wma_pkg::TOT_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/weighted_mean_accumulator_core.sv]
// Result path: each item is captured with its store read in S_IDLE, then
// S_RMW loads its result once the output register is free; a read with a
// nonzero divisor first runs the 64-step divider in S_DIV. A new item is
// taken only once the last is done (memory read, then modify and write back).
// Reset: asynchronous, clears all sums (per-entry valid bits), totals, the
// consumed flag and the mode register at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Weighted mean accumulator core
// Per-element running sums in a memory with read-modify-write sequencing,
// saturating totals, and an iterative divider for the mean readout.
// ----------------------------------------------------------------------------
`include "weighted_mean_accumulator_core_defines.svh"

module weighted_mean_accumulator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: weighted_mode.
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: elem_index[5:0], sample_value[37:6], weight[53:38],
  // partial_sum[117:54], other_weight_total[149:118], other_count[181:150],
  // zero fill[183:182].
  input  logic [183:0] s_axis_tdata,
  // tuser: func[1:0].
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: mean_value[31:0].
  output logic [31:0]  m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]   m_axis_tuser
);

  // Control state.
  wma_pkg::state_e               state_q, state_d;
  logic                          mode_q;
  logic                          consumed_q;
  logic [wma_pkg::TOT_W-1:0]     wt_q;
  logic [wma_pkg::TOT_W-1:0]     cnt_q;
  logic                          out_valid_q;

  // Captured item.
  wma_pkg::func_e                func_q;
  logic [5:0]                    idx_q;
  logic signed [31:0]            sample_q;
  logic signed [15:0]            w_q;
  logic [wma_pkg::SUM_W-1:0]     psum_q;
  logic [wma_pkg::TOT_W-1:0]     owt_q;
  logic [wma_pkg::TOT_W-1:0]     ocnt_q;
  logic                          last_q;
  logic signed [47:0]            prod_q;
  logic                          neg_q;

  // Result register.
  logic [wma_pkg::MEAN_W-1:0]    mean_q;
  wma_pkg::status_e              status_q;

  // Datapath and control signals.
  wma_pkg::ram_req_t             ram_req;
  logic [wma_pkg::SUM_W-1:0]     ram_rdata;
  logic                          div_start;
  logic                          div_busy;
  logic [wma_pkg::SUM_W-1:0]     div_quo;
  logic                          in_accept;
  logic                          out_free;
  logic                          in_range;
  logic [wma_pkg::SUM_W-1:0]     sum_cur;
  logic [wma_pkg::SUM_W-1:0]     addend;
  logic [wma_pkg::SUM_W:0]       sum_ext;
  logic [wma_pkg::SUM_W-1:0]     sum_sat;
  logic [wma_pkg::TOT_W-1:0]     wt_add;
  logic [wma_pkg::TOT_W-1:0]     cnt_add;
  logic [wma_pkg::TOT_W:0]       wt_ext;
  logic [wma_pkg::TOT_W:0]       cnt_ext;
  logic [wma_pkg::TOT_W-1:0]     divisor;
  logic [wma_pkg::SUM_W-1:0]     dividend;
  logic                          go_div;
  logic                          commit;
  wma_pkg::status_e              rmw_status;
  logic [wma_pkg::MEAN_W-1:0]    mean_sat;
  logic                          out_load;
  logic [wma_pkg::MEAN_W-1:0]    res_mean;
  wma_pkg::status_e              res_status;
  logic                          tot_we;
  logic                          cons_set;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  // Sum store and divider.
  wma_sum_ram u_sum_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  wma_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Item capture; the product is formed on the way into its register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= wma_pkg::func_e'(s_axis_tuser);
      idx_q    <= s_axis_tdata[5:0];
      sample_q <= s_axis_tdata[37:6];
      w_q      <= s_axis_tdata[53:38];
      psum_q   <= s_axis_tdata[117:54];
      owt_q    <= s_axis_tdata[149:118];
      ocnt_q   <= s_axis_tdata[181:150];
      last_q   <= s_axis_tlast;
      prod_q   <= $signed(s_axis_tdata[37:6]) * $signed(s_axis_tdata[53:38]);
    end
  end

  // Modify datapath: saturating element sum and saturating totals.
  always_comb begin
    in_range = (32'(idx_q) < 32'(wma_pkg::VECTOR_LEN));
    sum_cur  = in_range ? ram_rdata : '0;
    case (func_q)
      wma_pkg::FUNC_ACC: begin
        addend  = mode_q ? {{16{prod_q[47]}}, prod_q} : {{32{sample_q[31]}}, sample_q};
        wt_add  = mode_q ? {16'd0, w_q} : '0;
        cnt_add = wma_pkg::TOT_W'(1);
      end
      default: begin
        addend  = psum_q;
        wt_add  = owt_q;
        cnt_add = ocnt_q;
      end
    endcase
    sum_ext = {sum_cur[wma_pkg::SUM_W-1], sum_cur} + {addend[wma_pkg::SUM_W-1], addend};
    if (sum_ext[wma_pkg::SUM_W] != sum_ext[wma_pkg::SUM_W-1]) begin
      sum_sat = sum_ext[wma_pkg::SUM_W] ? {1'b1, {(wma_pkg::SUM_W-1){1'b0}}}
                                        : {1'b0, {(wma_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[wma_pkg::SUM_W-1:0];
    end
    wt_ext  = {1'b0, wt_q} + {1'b0, wt_add};
    cnt_ext = {1'b0, cnt_q} + {1'b0, cnt_add};
  end

  // Readout operands and saturation of the quotient.
  always_comb begin
    divisor  = (wt_q != '0) ? wt_q : cnt_q;
    dividend = sum_cur[wma_pkg::SUM_W-1] ? ('0 - sum_cur) : sum_cur;
    if (neg_q) begin
      mean_sat = (div_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                     : ('0 - div_quo[wma_pkg::MEAN_W-1:0]);
    end else begin
      mean_sat = (div_quo > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                     : div_quo[wma_pkg::MEAN_W-1:0];
    end
  end

  // Item decode: which update applies and the status it reports.
  always_comb begin
    commit     = 1'b0;
    go_div     = 1'b0;
    rmw_status = wma_pkg::ST_OK;
    case (func_q)
      wma_pkg::FUNC_ACC: begin
        if (consumed_q) begin
          rmw_status = wma_pkg::ST_CONSUMED;
        end else if (mode_q && (w_q[15] || (w_q == '0))) begin
          rmw_status = wma_pkg::ST_WEIGHT;
        end else begin
          commit = 1'b1;
        end
      end
      wma_pkg::FUNC_MERGE: begin
        if (consumed_q) begin
          rmw_status = wma_pkg::ST_CONSUMED;
        end else begin
          commit = 1'b1;
        end
      end
      wma_pkg::FUNC_READ: begin
        if (divisor == '0) begin
          rmw_status = wma_pkg::ST_ZERODIV;
        end else begin
          go_div = 1'b1;
        end
      end
      default: begin
        rmw_status = wma_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wma_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = wma_pkg::S_RMW;
        end
      end
      wma_pkg::S_RMW: begin
        if (go_div) begin
          state_d = wma_pkg::S_DIV;
        end else if (out_free) begin
          state_d = wma_pkg::S_IDLE;
        end
      end
      wma_pkg::S_DIV: begin
        if (!div_busy && out_free) begin
          state_d = wma_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wma_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_req       = '0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    res_mean      = '0;
    res_status    = wma_pkg::ST_OK;
    tot_we        = 1'b0;
    cons_set      = 1'b0;
    case (state_q)
      wma_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_req.re    = s_axis_tvalid;
        ram_req.addr  = wma_pkg::ADDR_W'(s_axis_tdata[5:0]);
      end
      wma_pkg::S_RMW: begin
        cons_set      = (func_q == wma_pkg::FUNC_READ);
        div_start     = go_div;
        ram_req.addr  = wma_pkg::ADDR_W'(idx_q);
        ram_req.wdata = sum_sat;
        if (!go_div && out_free) begin
          out_load   = 1'b1;
          res_status = rmw_status;
          ram_req.we = commit && in_range;
          tot_we     = commit && last_q;
        end
      end
      wma_pkg::S_DIV: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          res_mean = mean_sat;
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Sequencer state, totals and consumed flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wma_pkg::S_IDLE;
      wt_q       <= '0;
      cnt_q      <= '0;
      consumed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tot_we) begin
        wt_q  <= wt_ext[wma_pkg::TOT_W]  ? '1 : wt_ext[wma_pkg::TOT_W-1:0];
        cnt_q <= cnt_ext[wma_pkg::TOT_W] ? '1 : cnt_ext[wma_pkg::TOT_W-1:0];
      end
      if (cons_set) begin
        consumed_q <= 1'b1;
      end
    end
  end

  // Sign of the dividend for the readout.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q <= sum_cur[wma_pkg::SUM_W-1];
    end
  end

  // Output register decouples the result from the downstream ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q   <= res_mean;
      status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mean_q;
  assign m_axis_tuser  = status_q;

  // Checks on sequencing.
  `WMA_ASSERT(a_ram_single_port, !(ram_req.re && ram_req.we), "store read and write at once")
  `WMA_ASSERT(a_ram_we_in_rmw, ram_req.we |-> (state_q == wma_pkg::S_RMW), "stray store write")
  `WMA_ASSERT(a_div_start_busy, div_start |=> div_busy, "divider did not start")
  `WMA_ASSERT(a_consumed_sticky, consumed_q |=> consumed_q, "consumed flag cleared")
  `WMA_ASSERT(a_load_needs_room, out_load |-> out_free, "result loaded over an untaken result")

endmodule

[dv/tb_weighted_mean_accumulator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted mean accumulator core testbench
// Drives accumulate, merge, read and spare items through the input stream,
// predicts each result with a cycle-free model of the sums and totals, and
// checks every output transfer in order. The sender works in bursts and the
// receiver stalls on changing patterns. Because a read freezes the totals for
// good, each run picks one way of building the divisor (zero, count only,
// saturated or moderate) and spends its write phase before the first read.
// ----------------------------------------------------------------------------
module tb_weighted_mean_accumulator_core;

  // Longest stretch with no transfer on either side. A correct run stays far
  // below this: a read waits on the divider, plus sender gaps and receiver stalls.
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // How the weight total and the count are built before the first read.
  typedef enum int {PLAN_ZERO, PLAN_COUNT, PLAN_SAT, PLAN_MODERATE} total_plan_e;

  // Receiver stall patterns.
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_e;

  typedef struct {
    logic [1:0]         func;
    logic [5:0]         elem;
    logic signed [31:0] sample;
    logic signed [15:0] weight;
    logic signed [63:0] psum;
    logic [31:0]        other_wt;
    logic [31:0]        other_cnt;
    logic               last;
  } acc_item_t;

  typedef struct {
    logic [31:0]      mean;
    wma_pkg::status_e status;
  } mean_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_wdata_i   = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  // Predicted state of the block.
  logic signed [63:0] elem_sums [wma_pkg::VECTOR_LEN];
  logic [31:0]        total_weight;
  logic [31:0]        contrib_count;
  logic               read_seen;
  logic               weighted_cfg;

  mean_result_t pending_means [$];
  total_plan_e  plan;
  int           burst_left = 0;
  int           mismatches = 0;
  rx_pattern_e  rx_pattern = RX_OPEN;
  int           rx_left    = 0;
  int           rx_phase   = 0;

  weighted_mean_accumulator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Element sums clip to the signed 64-bit range.
  function automatic logic signed [63:0] sat_add_sum(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) return s[64] ? SUM_MIN : SUM_MAX;
    return s[63:0];
  endfunction

  // Totals stick at all ones.
  function automatic logic [31:0] sat_add_total(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Quotient truncated toward zero, then clipped to the signed 32-bit range.
  function automatic logic [31:0] q16_quotient(input logic signed [63:0] sum,
                                               input logic [31:0] divisor);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = sum[63] ? ~sum + 64'd1 : sum;
    quo = mag / {32'd0, divisor};
    if (sum[63]) begin
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      quo = ~quo + 64'd1;
    end else if (quo > 64'h7FFF_FFFF) begin
      quo = 64'h7FFF_FFFF;
    end
    return quo[31:0];
  endfunction

  // Applies one accepted item to the predicted state and returns its result.
  function automatic mean_result_t apply_to_sums(input acc_item_t it);
    mean_result_t       res;
    logic signed [63:0] addend;
    logic [31:0]        divisor;
    logic               in_range;
    res.mean   = '0;
    res.status = wma_pkg::ST_OK;
    in_range   = (int'(it.elem) < wma_pkg::VECTOR_LEN);
    if (it.func == wma_pkg::FUNC_ACC || it.func == wma_pkg::FUNC_MERGE) begin
      // Writes after a read are refused before anything else is looked at.
      if (read_seen) begin
        res.status = wma_pkg::ST_CONSUMED;
      end else if (it.func == wma_pkg::FUNC_ACC && weighted_cfg && it.weight <= 0) begin
        res.status = wma_pkg::ST_WEIGHT;
      end else begin
        if (it.func == wma_pkg::FUNC_MERGE) addend = it.psum;
        else if (weighted_cfg) addend = it.sample * it.weight;
        else addend = it.sample;
        if (in_range) elem_sums[it.elem] = sat_add_sum(elem_sums[it.elem], addend);
        if (it.last) begin
          if (it.func == wma_pkg::FUNC_MERGE) begin
            total_weight  = sat_add_total(total_weight, it.other_wt);
            contrib_count = sat_add_total(contrib_count, it.other_cnt);
          end else begin
            if (weighted_cfg) total_weight = sat_add_total(total_weight, {16'd0, it.weight});
            contrib_count = sat_add_total(contrib_count, 32'd1);
          end
        end
      end
    end else if (it.func == wma_pkg::FUNC_READ) begin
      // The count stands in for the weight total while that total is zero.
      divisor   = (total_weight != 0) ? total_weight : contrib_count;
      read_seen = 1'b1;
      if (divisor == 0) res.status = wma_pkg::ST_ZERODIV;
      else res.mean = q16_quotient(in_range ? elem_sums[it.elem] : 64'sd0, divisor);
    end
    return res;
  endfunction

  // Every field random over its whole width.
  function automatic acc_item_t noise_item();
    acc_item_t it;
    it.func      = 2'($urandom_range(0, 3));
    it.elem      = 6'($urandom_range(0, wma_pkg::VECTOR_LEN - 1));
    it.sample    = $urandom;
    it.weight    = 16'($urandom);
    it.psum      = {$urandom, $urandom};
    it.other_wt  = $urandom;
    it.other_cnt = $urandom;
    it.last      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Before the first read, keeps the totals on the course chosen for this run.
  function automatic acc_item_t fit_to_plan(input acc_item_t it);
    if (read_seen) return it;
    if (it.func == wma_pkg::FUNC_ACC &&
        (plan == PLAN_ZERO || (plan == PLAN_COUNT && weighted_cfg)))
      it.last = 1'b0;
    if (it.func == wma_pkg::FUNC_MERGE && it.last) begin
      case (plan)
        PLAN_ZERO: begin
          it.other_wt  = '0;
          it.other_cnt = '0;
        end
        PLAN_COUNT: begin
          it.other_wt  = '0;
          it.other_cnt = $urandom_range(0, 15);
        end
        PLAN_SAT: begin
          it.other_wt  |= 32'h8000_0000;
          it.other_cnt |= 32'h8000_0000;
        end
        default: begin
          it.other_wt  = $urandom_range(0, 255);
          it.other_cnt = $urandom_range(0, 15);
        end
      endcase
    end
    return it;
  endfunction

  // Mostly accumulates and merges with realistic operands, some spare codes.
  function automatic acc_item_t random_update();
    acc_item_t   it;
    int          pick;
    logic [63:0] wide;
    it   = noise_item();
    pick = $urandom_range(0, 19);
    wide = {$urandom, $urandom};
    it.last = ($urandom_range(0, 5) == 0);
    if (pick < 11) begin
      it.func = wma_pkg::FUNC_ACC;
      if ($urandom_range(0, 1)) it.sample = {{11{wide[20]}}, wide[20:0]};
      if (weighted_cfg && $urandom_range(0, 6) != 0)
        it.weight = $urandom_range(0, 1) ? 16'($urandom_range(1, 32767))
                                         : 16'($urandom_range(1, 16));
    end else if (pick < 18) begin
      it.func = wma_pkg::FUNC_MERGE;
      if ($urandom_range(0, 15) != 0) it.psum = {{16{wide[47]}}, wide[47:0]};
    end else begin
      it.func = FUNC_SPARE;
    end
    return fit_to_plan(it);
  endfunction

  // Sends one item and records its predicted result at the transfer.
  task automatic push_item(input acc_item_t it);
    mean_result_t res;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.other_cnt, it.other_wt, it.psum, it.weight, it.sample,
                      it.elem};
    s_axis_tuser  <= it.func;
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    res = apply_to_sums(it);
    pending_means.insert(pending_means.size(), res);
    burst_left--;
  endtask

  task automatic send_acc(input logic [5:0] elem, input logic signed [31:0] sample,
                          input logic signed [15:0] weight, input logic last);
    acc_item_t it;
    it        = noise_item();
    it.func   = wma_pkg::FUNC_ACC;
    it.elem   = elem;
    it.sample = sample;
    it.weight = weight;
    it.last   = last;
    push_item(fit_to_plan(it));
  endtask

  task automatic send_merge(input logic [5:0] elem, input logic signed [63:0] psum,
                            input logic [31:0] other_wt, input logic [31:0] other_cnt,
                            input logic last);
    acc_item_t it;
    it           = noise_item();
    it.func      = wma_pkg::FUNC_MERGE;
    it.elem      = elem;
    it.psum      = psum;
    it.other_wt  = other_wt;
    it.other_cnt = other_cnt;
    it.last      = last;
    push_item(fit_to_plan(it));
  endtask

  task automatic send_read(input logic [5:0] elem);
    acc_item_t it;
    it      = noise_item();
    it.func = wma_pkg::FUNC_READ;
    it.elem = elem;
    push_item(it);
  endtask

  // Stops sending and waits until every outstanding result has been taken.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic weighted);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= weighted;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    weighted_cfg = weighted;
  endtask

  // Plain mode: sample extremes, the weight is ignored even when negative.
  task automatic test_plain_mode();
    acc_item_t it;
    set_mode(1'b0);
    send_acc(6'd0, 32'h7FFF_FFFF, 16'sh8000, 1'b0);
    send_acc(6'd0, 32'h8000_0000, 16'sh7FFF, 1'b0);
    send_acc(6'd63, 32'hFFFF_FFFF, 16'sd0, 1'b1);
    send_acc(6'd63, 32'h0001_0000, -16'sd1, 1'b0);
    // The spare function code has no effect and completes with status ok.
    it      = noise_item();
    it.func = FUNC_SPARE;
    push_item(it);
  endtask

  // Weighted mode: nonpositive weights are refused, weight extremes scale.
  task automatic test_weighted_mode();
    set_mode(1'b1);
    send_acc(6'd1, 32'h0001_0000, 16'sd0, 1'b1);
    send_acc(6'd1, 32'h0001_0000, -16'sd1, 1'b0);
    send_acc(6'd1, 32'h0001_0000, 16'sh8000, 1'b1);
    send_acc(6'd2, 32'h7FFF_FFFF, 16'sh7FFF, 1'b0);
    send_acc(6'd2, 32'h8000_0000, 16'sh7FFF, 1'b1);
    send_acc(6'd3, 32'h8000_0000, 16'sd1, 1'b0);
  endtask

  // Merges that drive sums into both saturation limits, then apply totals.
  task automatic test_merge_saturation();
    send_merge(6'd4, SUM_MAX, 32'd3, 32'd2, 1'b0);
    send_merge(6'd4, SUM_MAX, 32'd3, 32'd2, 1'b0);
    send_acc(6'd4, 32'h7FFF_FFFF, 16'sh7FFF, 1'b0);
    send_merge(6'd5, SUM_MIN, 32'd0, 32'd0, 1'b0);
    send_merge(6'd5, SUM_MIN, 32'd0, 32'd0, 1'b0);
    send_merge(6'd6, 64'sd0, 32'd7, 32'd1, 1'b1);
  endtask

  // Random updates in chunks, each chunk under its own mode setting.
  task automatic test_random_updates(input int count);
    for (int chunk = 0; chunk < 5; chunk++) begin
      set_mode((chunk == 0) ? 1'b0 : (chunk == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      repeat (count / 5) push_item(random_update());
    end
  endtask

  // The first read freezes the state; later writes are refused, reads go on.
  task automatic test_readout(input int count);
    send_read(6'd4);
    send_read(6'd5);
    send_read(6'd63);
    send_read(6'd0);
    send_acc(6'd10, 32'h0001_0000, 16'sd1, 1'b1);
    send_merge(6'd10, SUM_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    set_mode(1'b1);
    // A refused write outranks a nonpositive weight.
    send_acc(6'd10, 32'h0001_0000, 16'sh8000, 1'b1);
    send_read(6'd10);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) set_mode(1'b0);
      if ($urandom_range(0, 9) < 7)
        send_read(6'($urandom_range(0, wma_pkg::VECTOR_LEN - 1)));
      else push_item(random_update());
    end
  endtask

  // Result side: checks each output transfer and sets the stall pattern.
  always @(posedge clk_i) begin : result_side
    mean_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: mean=%h status=%0d",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_means.pop_front();
        if (m_axis_tdata !== want.mean || m_axis_tuser !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected mean=%h status=%0d, got mean=%h status=%0d",
                     $time, want.mean, want.status, m_axis_tdata, m_axis_tuser);
        end
      end
    end
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left    = $urandom_range(50, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_pattern)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready <= (rx_phase % 4 == 0);
      default:     m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Ends the run when neither side has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    foreach (elem_sums[i]) elem_sums[i] = '0;
    total_weight  = '0;
    contrib_count = '0;
    read_seen     = 1'b0;
    weighted_cfg  = 1'b0;
    case ($urandom_range(0, 9))
      0:       plan = PLAN_ZERO;
      1:       plan = PLAN_COUNT;
      2:       plan = PLAN_SAT;
      default: plan = PLAN_MODERATE;
    endcase
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_mode();
    test_weighted_mode();
    test_merge_saturation();
    test_random_updates(450);
    test_readout(270);

    // Drain, then allow a full read latency for any stray result.
    wait_idle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && pending_means.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
